// File: rtl/core/cab_pkg.sv
// shared types, codes and arithmetic helpers for the clipped alpha blit
package cab_pkg;

    // largest destination dimension, larger sizes clamp to it
    localparam int MAX_DIM = 4096;

    // blend modes
    localparam logic [1:0] MODE_COPY     = 2'd0;
    localparam logic [1:0] MODE_COPY_OPQ = 2'd1;
    localparam logic [1:0] MODE_BLEND    = 2'd2;
    localparam logic [1:0] MODE_OVER     = 2'd3;

    // register indexes
    localparam logic [2:0] REG_DEST_WIDTH  = 3'd0;
    localparam logic [2:0] REG_DEST_HEIGHT = 3'd1;
    localparam logic [2:0] REG_OFFSET_X    = 3'd2;
    localparam logic [2:0] REG_OFFSET_Y    = 3'd3;
    localparam logic [2:0] REG_BLEND_MODE  = 3'd4;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic [12:0]        dest_width;
        logic [12:0]        dest_height;
        logic signed [13:0] offset_x;
        logic signed [13:0] offset_y;
    } t_geom;

    // classified request passed from front to back
    typedef struct packed {
        logic        in_win;
        logic [23:0] index;
        logic [7:0]  sr;
        logic [7:0]  sg;
        logic [7:0]  sb;
        logic [7:0]  sa;
        logic [7:0]  dr;
        logic [7:0]  dg;
        logic [7:0]  db;
        logic [7:0]  da;
    } t_item;

    // floor(x / 255): shift estimate then one correction step
    function automatic logic [16:0] div255(input logic [23:0] x);
        logic [24:0] s;
        logic [16:0] q1;
        logic [24:0] r;
        s  = {1'b0, x} + {9'd0, x[23:8]} + {17'd0, x[23:16]};
        q1 = s[24:8];
        r  = {1'b0, x} - ({q1, 8'd0} - {8'd0, q1});
        if (r >= 25'd255) begin
            q1 = q1 + 17'd1;
        end
        return q1;
    endfunction

    function automatic logic [7:0] sat255(input logic [16:0] v);
        return (v > 17'd255) ? 8'd255 : v[7:0];
    endfunction

endpackage

// File: rtl/core/cab_front.sv
// front stage: destination clipping and linear pixel index
module cab_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cab_pkg::t_geom       i_geom,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [87:0]          i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output cab_pkg::t_item       o_item
);
    import cab_pkg::*;

    logic        r_v;
    t_item       r_item;
    t_item       n_item;
    logic [12:0] w_w;
    logic [12:0] w_h;
    logic [14:0] w_px;
    logic [14:0] w_py;
    logic        w_in;
    logic [25:0] w_prod;

    // oversized dimensions clamp to MAX_DIM
    assign w_w = ({4'd0, i_geom.dest_width} > 17'(MAX_DIM)) ? 13'(MAX_DIM) : i_geom.dest_width;
    assign w_h = ({4'd0, i_geom.dest_height} > 17'(MAX_DIM)) ? 13'(MAX_DIM)
                                                              : i_geom.dest_height;

    assign w_px = {i_geom.offset_x[13], i_geom.offset_x} + {3'd0, i_data[11:0]};
    assign w_py = {i_geom.offset_y[13], i_geom.offset_y} + {3'd0, i_data[23:12]};
    assign w_in = !w_px[14] && !w_py[14]
               && (w_px[13:0] < {1'b0, w_w}) && (w_py[13:0] < {1'b0, w_h});
    assign w_prod = w_py[12:0] * w_w;

    always_comb begin
        n_item.in_win = w_in;
        n_item.index  = w_prod[23:0] + {11'd0, w_px[12:0]};
        n_item.sr     = i_data[31:24];
        n_item.sg     = i_data[39:32];
        n_item.sb     = i_data[47:40];
        n_item.sa     = i_data[55:48];
        n_item.dr     = i_data[63:56];
        n_item.dg     = i_data[71:64];
        n_item.db     = i_data[79:72];
        n_item.da     = i_data[87:80];
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// File: rtl/core/cab_fifo.sv
// short request queue between front and back
module cab_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cab_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output cab_pkg::t_item o_item
);
    import cab_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_ready = (r_cnt != (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// File: rtl/core/cab_back.sv
// back pipeline: blend arithmetic and pipelined divide by result alpha
module cab_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_mode,
    input  logic           i_valid,
    output logic           o_ready,
    input  cab_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [56:0]    o_res
);
    import cab_pkg::*;

    localparam int NSTG = 13;

    logic            w_adv;
    logic [NSTG-1:0] r_vld;
    logic            r_ov;
    logic [56:0]     r_res;
    logic [56:0]     n_res;

    logic [7:0]  w_s [3];
    logic [7:0]  w_d [3];
    logic [7:0]  w_nsa;

    // stage 1: products
    t_item       r1_item;
    logic [15:0] r1_ssa [3];
    logic [15:0] r1_dna [3];
    logic [15:0] r1_dda [3];
    logic [15:0] r1_ona;
    // stage 2: second product and blend sum
    t_item       r2_item;
    logic [23:0] r2_t   [3];
    logic [16:0] r2_m2  [3];
    logic [15:0] r2_ssa [3];
    logic [15:0] r2_ona;
    // stage 3: divisions by 255
    t_item       r3_item;
    logic [16:0] r3_tq  [3];
    logic [7:0]  r3_m2q [3];
    logic [15:0] r3_ssa [3];
    logic [7:0]  r3_oa;
    // stage 4: numerator
    t_item       r4_item;
    logic [17:0] r4_num [3];
    logic [7:0]  r4_m2q [3];
    logic [7:0]  r4_oa;
    // divider stages: saturation check, then one quotient bit each
    t_item       rd_item [9];
    logic [17:0] rd_rem  [9][3];
    logic [7:0]  rd_q    [9][3];
    logic        rd_sat  [9][3];
    logic [7:0]  rd_m2q  [9][3];
    logic [7:0]  rd_oa   [9];

    logic [16:0] w_ona_q;
    logic [8:0]  w_oa9;
    logic [7:0]  w_c   [3];
    t_item       w_fi;

    assign w_adv   = !r_ov || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    assign w_s[0] = i_item.sr;
    assign w_s[1] = i_item.sg;
    assign w_s[2] = i_item.sb;
    assign w_d[0] = i_item.dr;
    assign w_d[1] = i_item.dg;
    assign w_d[2] = i_item.db;
    assign w_nsa  = 8'd255 - i_item.sa;

    assign w_ona_q = div255({8'd0, r2_ona});
    assign w_oa9   = {1'b0, r2_item.sa} + w_ona_q[8:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
            r_ov  <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_item <= i_item;
            r1_ona  <= 16'(i_item.da) * 16'(w_nsa);
            r2_item <= r1_item;
            r2_ona  <= r1_ona;
            r3_item <= r2_item;
            r3_oa   <= w_oa9[7:0];
            r4_item <= r3_item;
            r4_oa   <= r3_oa;
            rd_item[0] <= r4_item;
            rd_oa[0]   <= r4_oa;
            for (int k = 0; k < 3; k++) begin
                r1_ssa[k] <= 16'(w_s[k]) * 16'(i_item.sa);
                r1_dna[k] <= 16'(w_d[k]) * 16'(w_nsa);
                r1_dda[k] <= 16'(w_d[k]) * 16'(i_item.da);
                r2_t[k]   <= 24'(r1_dda[k]) * 24'(8'd255 - r1_item.sa);
                r2_m2[k]  <= {1'b0, r1_ssa[k]} + {1'b0, r1_dna[k]};
                r2_ssa[k] <= r1_ssa[k];
                r3_tq[k]  <= div255(r2_t[k]);
                r3_m2q[k] <= sat255(div255({7'd0, r2_m2[k]}));
                r3_ssa[k] <= r2_ssa[k];
                r4_num[k] <= {2'd0, r3_ssa[k]} + {1'b0, r3_tq[k]};
                r4_m2q[k] <= r3_m2q[k];
                // quotient of 256 or more saturates
                rd_sat[0][k] <= (r4_num[k] >= {2'd0, r4_oa, 8'd0});
                rd_rem[0][k] <= r4_num[k];
                rd_q[0][k]   <= '0;
                rd_m2q[0][k] <= r4_m2q[k];
            end
            for (int j = 0; j < 8; j++) begin
                rd_item[j+1] <= rd_item[j];
                rd_oa[j+1]   <= rd_oa[j];
                for (int k = 0; k < 3; k++) begin
                    rd_sat[j+1][k] <= rd_sat[j][k];
                    rd_m2q[j+1][k] <= rd_m2q[j][k];
                    if (rd_rem[j][k] >= (18'(rd_oa[j]) << (7 - j))) begin
                        rd_rem[j+1][k] <= rd_rem[j][k] - (18'(rd_oa[j]) << (7 - j));
                        rd_q[j+1][k]   <= rd_q[j][k] | (8'd1 << (7 - j));
                    end else begin
                        rd_rem[j+1][k] <= rd_rem[j][k];
                        rd_q[j+1][k]   <= rd_q[j][k];
                    end
                end
            end
            r_res <= n_res;
        end
    end

    assign w_fi = rd_item[8];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_c[k] = rd_sat[8][k] ? 8'd255 : rd_q[8][k];
        end
        n_res = '0;
        if (w_fi.in_win) begin
            n_res[0]    = 1'b1;
            n_res[24:1] = w_fi.index;
            unique case (i_mode)
                MODE_COPY: begin
                    n_res[56:25] = {w_fi.da, w_fi.sb, w_fi.sg, w_fi.sr};
                end
                MODE_COPY_OPQ: begin
                    n_res[56:25] = {8'd255, w_fi.sb, w_fi.sg, w_fi.sr};
                end
                MODE_BLEND: begin
                    n_res[56:25] = {w_fi.da, rd_m2q[8][2], rd_m2q[8][1], rd_m2q[8][0]};
                end
                MODE_OVER: begin
                    if (rd_oa[8] == 8'd0) begin
                        n_res[0]     = 1'b0;
                        n_res[56:25] = {w_fi.da, w_fi.db, w_fi.dg, w_fi.dr};
                    end else begin
                        n_res[56:25] = {rd_oa[8], w_c[2], w_c[1], w_c[0]};
                    end
                end
                default: begin
                    n_res = '0;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/clipped_alpha_blit.sv
// clipped alpha blit top level: config registers, front, queue, back
// throughput: one pixel per cycle while the result stream is not stalled, the divide by
//   result alpha is pipelined and takes a new pixel every cycle
// reset: synchronous active-low, empties every stage and the queue and
//   loads the register reset values (640 x 480, offset 0, over mode)
module clipped_alpha_blit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // rel_x[11:0] rel_y[23:12] src r,g,b,a [55:24] dst r,g,b,a [87:56]
    input  logic [87:0] s_axis_tdata,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // write_enable[0] pixel_index[24:1] out r,g,b,a [56:25] zero [63:57]
    output logic [63:0] m_axis_tdata,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cab_pkg::*;

    logic [12:0]        r_dest_width;
    logic [12:0]        r_dest_height;
    logic signed [13:0] r_offset_x;
    logic signed [13:0] r_offset_y;
    logic [1:0]         r_blend_mode;
    t_geom              w_geom;
    logic               w_wr;

    logic               w_f_valid;
    logic               w_f_ready;
    t_item              w_f_item;
    logic               w_q_valid;
    logic               w_q_ready;
    t_item              w_q_item;
    logic [56:0]        w_res;

    // in-flight request count, used only by the checks below
    logic [5:0]         r_inflight;

    // config write on the access phase
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_width  <= 13'd640;
            r_dest_height <= 13'd480;
            r_offset_x    <= '0;
            r_offset_y    <= '0;
            r_blend_mode  <= MODE_OVER;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_DEST_WIDTH:  r_dest_width  <= pwdata[12:0];
                REG_DEST_HEIGHT: r_dest_height <= pwdata[12:0];
                REG_OFFSET_X:    r_offset_x    <= pwdata[13:0];
                REG_OFFSET_Y:    r_offset_y    <= pwdata[13:0];
                REG_BLEND_MODE:  r_blend_mode  <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback, offsets shown as their raw 14-bit fields
    always_comb begin
        unique case (paddr[4:2])
            REG_DEST_WIDTH:  prdata = {19'd0, r_dest_width};
            REG_DEST_HEIGHT: prdata = {19'd0, r_dest_height};
            REG_OFFSET_X:    prdata = {18'd0, r_offset_x};
            REG_OFFSET_Y:    prdata = {18'd0, r_offset_y};
            REG_BLEND_MODE:  prdata = {30'd0, r_blend_mode};
            default:         prdata = '0;
        endcase
    end

    assign w_geom.dest_width  = r_dest_width;
    assign w_geom.dest_height = r_dest_height;
    assign w_geom.offset_x    = r_offset_x;
    assign w_geom.offset_y    = r_offset_y;

    // front: clip test and row * width + column
    cab_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (w_geom),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_item  (w_f_item)
    );

    // queue decouples front from back stalls
    cab_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    // back: blend math, divide, output register
    cab_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_blend_mode),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_item  (w_q_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res)
    );

    assign m_axis_tdata = {7'd0, w_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight
                        + {5'd0, s_axis_tvalid && s_axis_tready}
                        - {5'd0, m_axis_tvalid && m_axis_tready};
        end
    end

    // no result without a matching request in flight
    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_inflight != 6'd0))
        else $error("result with no request in flight");

    // front, queue, back stages and output register bound the occupancy
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 6'd19)
        else $error("in-flight count beyond pipeline capacity");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // padding bits above the result pixel stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[63:57] == 7'd0))
        else $error("padding bits set on result");

endmodule

// File: tb/clipped_alpha_blit_checker.sv
// result checker for the clipped alpha blit: predicts each pixel and compares results
`timescale 1ns / 1ps

module clipped_alpha_blit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_written
);
    import cab_pkg::*;

    logic [12:0]        width_q;
    logic [12:0]        height_q;
    logic signed [13:0] off_x_q;
    logic signed [13:0] off_y_q;
    logic [1:0]         mode_q;

    logic [63:0] pixel_q[$];

    function automatic logic [7:0] clamp255(input int unsigned v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [63:0] blend_pixel(input logic [87:0] d);
        int          w;
        int          h;
        int          px;
        int          py;
        int unsigned s[3];
        int unsigned c[3];
        int unsigned sa;
        int unsigned da;
        int unsigned oa;
        logic [7:0]  o[3];
        logic [7:0]  oalpha;
        logic        we;
        logic [23:0] idx;
        w  = (width_q > 13'd4096) ? 4096 : int'(width_q);
        h  = (height_q > 13'd4096) ? 4096 : int'(height_q);
        px = int'(off_x_q) + int'(d[11:0]);
        py = int'(off_y_q) + int'(d[23:12]);
        if (px < 0 || px >= w || py < 0 || py >= h) begin
            return 64'd0;
        end
        idx = 24'(py * w + px);
        for (int k = 0; k < 3; k++) begin
            s[k] = 32'(d[24 + 8*k +: 8]);
            c[k] = 32'(d[56 + 8*k +: 8]);
        end
        sa = 32'(d[55:48]);
        da = 32'(d[87:80]);
        we = 1'b1;
        oalpha = 8'(da);
        case (mode_q)
            MODE_COPY, MODE_COPY_OPQ: begin
                for (int k = 0; k < 3; k++) o[k] = 8'(s[k]);
                if (mode_q == MODE_COPY_OPQ) oalpha = 8'd255;
            end
            MODE_BLEND: begin
                for (int k = 0; k < 3; k++)
                    o[k] = clamp255((s[k] * sa + c[k] * (255 - sa)) / 255);
            end
            default: begin
                oa = sa + (da * (255 - sa)) / 255;
                if (oa == 0) begin
                    // fully transparent result: keep destination, no write
                    we = 1'b0;
                    for (int k = 0; k < 3; k++) o[k] = 8'(c[k]);
                end else begin
                    for (int k = 0; k < 3; k++)
                        o[k] = clamp255((s[k] * sa + (c[k] * da * (255 - sa)) / 255) / oa);
                    oalpha = clamp255(oa);
                end
            end
        endcase
        return {7'd0, oalpha, o[2], o[1], o[0], idx, we};
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            o_errors++;
            if (o_errors <= 10)
                $display("mismatch %s: expected %0h got %0h (result %0d)",
                         name, exp_v, act_v, o_results);
        end
    endtask

    always @(posedge i_clk) begin
        logic [63:0] exp_px;
        if (!i_rst_n) begin
            width_q  <= 13'd640;
            height_q <= 13'd480;
            off_x_q  <= '0;
            off_y_q  <= '0;
            mode_q   <= MODE_OVER;
            pixel_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                o_written++;
                case (paddr[4:2])
                    REG_DEST_WIDTH:  width_q  <= pwdata[12:0];
                    REG_DEST_HEIGHT: height_q <= pwdata[12:0];
                    REG_OFFSET_X:    off_x_q  <= pwdata[13:0];
                    REG_OFFSET_Y:    off_y_q  <= pwdata[13:0];
                    REG_BLEND_MODE:  mode_q   <= pwdata[1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                pixel_q.push_back(blend_pixel(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                o_results++;
                if (pixel_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result %0h", m_axis_tdata);
                end else begin
                    exp_px = pixel_q.pop_front();
                    check_field("write_enable", 32'(exp_px[0]), 32'(m_axis_tdata[0]));
                    check_field("pixel_index", 32'(exp_px[24:1]), 32'(m_axis_tdata[24:1]));
                    check_field("out_red", 32'(exp_px[32:25]), 32'(m_axis_tdata[32:25]));
                    check_field("out_green", 32'(exp_px[40:33]), 32'(m_axis_tdata[40:33]));
                    check_field("out_blue", 32'(exp_px[48:41]), 32'(m_axis_tdata[48:41]));
                    check_field("new_alpha", 32'(exp_px[56:49]), 32'(m_axis_tdata[56:49]));
                    check_field("pad", 32'(exp_px[63:57]), 32'(m_axis_tdata[63:57]));
                end
            end
        end
        o_pending = pixel_q.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
        o_written = 0;
    end

endmodule

// File: tb/tb.sv
// top-level testbench for the clipped alpha blit: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;
    import cab_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // rel_x, rel_y, src r,g,b,a, dst r,g,b,a from the lowest bit up
    logic [87:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // write_enable, pixel_index, out r,g,b,a, zero pad from the lowest bit up
    logic [63:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int results;
    int written;

    // flow-control profile: percent of cycles each side holds off
    int send_idle;
    int recv_idle;
    int sent;
    int stall_cycles;

    // geometry as last programmed, used to aim requests near the clip window
    int cur_w;
    int cur_ox;
    int cur_h;
    int cur_oy;

    clipped_alpha_blit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    clipped_alpha_blit_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_results     (results),
        .o_written     (written)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog: any cycle without a handshake of any kind counts toward the limit
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 3000) begin
            $display("FAIL clipped_alpha_blit");
            $finish;
        end
    end

    // channel value biased toward the extremes
    function automatic logic [7:0] pick_channel();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // relative coordinate that mostly lands within two pixels of the clip window
    function automatic logic [11:0] pick_rel(input int size, input int off);
        int target;
        int rel;
        if ($urandom_range(9) < 3)
            return 12'($urandom);
        target = int'($urandom_range(size + 3)) - 2;
        rel = target - off;
        if (rel < 0) rel = 0;
        if (rel > 4095) rel = 4095;
        return 12'(rel);
    endfunction

    task automatic send_pixel(input logic [11:0] rx, input logic [11:0] ry,
                              input logic [31:0] src, input logic [31:0] dst);
        // sender idles for a random number of cycles before some requests
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dst, src, ry, rx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
        // idle profile moves on by thirds of the run
        if (sent == 317) begin
            send_idle = 78;
            recv_idle = 16;
        end else if (sent == 634) begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    task automatic random_pixel();
        send_pixel(pick_rel(cur_w, cur_ox), pick_rel(cur_h, cur_oy),
                   {pick_channel(), pick_channel(), pick_channel(), pick_channel()},
                   {pick_channel(), pick_channel(), pick_channel(), pick_channel()});
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drain the pipe, then program a whole new geometry and mode
    task automatic set_geometry(input int w, input int h, input int ox, input int oy,
                                input logic [1:0] mode);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        write_reg(REG_DEST_WIDTH, 32'(w));
        write_reg(REG_DEST_HEIGHT, 32'(h));
        write_reg(REG_OFFSET_X, 32'(ox));
        write_reg(REG_OFFSET_Y, 32'(oy));
        write_reg(REG_BLEND_MODE, 32'(mode));
        cur_w  = (w > 4096) ? 4096 : w;
        cur_h  = (h > 4096) ? 4096 : h;
        cur_ox = ox;
        cur_oy = oy;
    endtask

    initial begin
        int gw[9];
        int gh[9];
        int gx[9];
        int gy[9];
        logic [1:0] gm[9];
        // geometry sweep: full size, oversize clamp, zero width, single pixel,
        // offsets at both extremes, every blend mode
        gw = '{4096, 8191, 100,  0,   1,  333, 4095, 257, 640};
        gh = '{4096, 8191, 50,   17,  1, 4096,    2, 300, 480};
        gx = '{0,   -4096, -37,  0,   0, -4096,   5, 4096, 3};
        gy = '{0,    4096, 25,   0,   0, -100,    0, -4096, -2};
        gm = '{MODE_COPY, MODE_BLEND, MODE_OVER, MODE_COPY_OPQ, MODE_BLEND,
               MODE_OVER, MODE_COPY_OPQ, MODE_COPY, MODE_OVER};
        send_idle = 16;
        recv_idle = 78;
        sent = 0;
        stall_cycles = 0;
        cur_w = 640;
        cur_h = 480;
        cur_ox = 0;
        cur_oy = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pixels at reset geometry, over mode
        send_pixel(12'd0, 12'd0, 32'h00ffffff, 32'h00ffffff);   // zero result alpha
        send_pixel(12'd639, 12'd479, 32'hffffffff, 32'hffffffff);
        send_pixel(12'd640, 12'd0, 32'hffffffff, 32'hffffffff); // just right of edge
        send_pixel(12'd0, 12'd480, 32'h80102030, 32'h40506070); // just below edge
        send_pixel(12'd4095, 12'd4095, 32'h12345678, 32'h9abcdef0);
        send_pixel(12'd5, 12'd7, 32'h00000000, 32'hffa0b0c0);   // clear source on opaque
        send_pixel(12'd5, 12'd7, 32'hff112233, 32'h00445566);   // opaque source
        send_pixel(12'd1, 12'd1, 32'h01ffffff, 32'h01ffffff);   // tiny alpha, saturation
        send_pixel(12'd2, 12'd3, 32'h80ff00ff, 32'h4000ff00);
        send_pixel(12'd100, 12'd200, 32'h7f808080, 32'hfe7f7f7f);
        send_pixel(12'h555, 12'haaa, 32'h55aa55aa, 32'haa55aa55);

        for (int g = 0; g < 9; g++) begin
            set_geometry(gw[g], gh[g], gx[g], gy[g], gm[g]);
            // one pixel aimed at the top-left corner of the window
            send_pixel(12'((cur_ox < 0) ? -cur_ox : 0), 12'((cur_oy < 0) ? -cur_oy : 0),
                       32'hff00ff00, 32'h00ff00ff);
            for (int n = 0; n < 104; n++) random_pixel();
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d pixels over %0d register writes and 10 geometries, all modes",
                 sent, written);
        $display("checked %0d results, %0d field mismatches", results, errors);
        if (errors == 0 && pending == 0)
            $display("PASS clipped_alpha_blit");
        else
            $display("FAIL clipped_alpha_blit");
        $finish;
    end

endmodule

// File: files.f
rtl/core/cab_pkg.sv
rtl/core/cab_front.sv
rtl/core/cab_fifo.sv
rtl/core/cab_back.sv
rtl/core/clipped_alpha_blit.sv
tb/clipped_alpha_blit_checker.sv
tb/tb.sv
